FILE: sv/idel_pkg.sv
package idel_pkg;

  // Default list depth
  localparam int CAPACITY = 64;

  // Operation codes
  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_AT   = 3'd2,
    OP_REM_HEAD = 3'd3,
    OP_REM_TAIL = 3'd4,
    OP_REM_AT   = 3'd5,
    OP_SEARCH   = 3'd6,
    OP_NONE     = 3'd7
  } op_t;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch a new transaction
    logic step;    // advance the move / compare sweep
    logic finish;  // final write, count update, result load
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ins;     // accepted op is a valid insert
    logic rem;     // accepted op is a valid remove
    logic srch;    // accepted op is a search
    logic more;    // sweep still has entries to read
  } stat_t;

endpackage

FILE: sv/indexed_double_ended_list_core.sv
// Ordered list of up to CAPACITY signed 32-bit entries, numbered from the
// head. Input transactions carry op, index and value; each one returns a
// single result transaction with found, status and the count afterward.
// Both channels use valid/stall: a transaction moves on a clock edge with
// valid high and stall low.
// One transaction is worked at a time. Failing ops and the unused op
// code go straight to the result. An insert at k first moves entries k
// to the tail up one place, a remove at k moves the entries after k down
// one place, and a search compares every entry. The sweep moves or
// compares one entry per cycle, through one read and one write port of
// the entry memory. in_stall is high from accept until the
// result is loaded. A finished result waits in the output register while
// out_stall is high; the next input is taken once it is loaded.
// Reset (rst, synchronous) empties the list at once; no clearing pass.
// Entry contents are not reset.
module indexed_double_ended_list_core #(
  parameter int CAPACITY = idel_pkg::CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic [CNT_W-1:0]   index,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [1:0]         status,
  output logic [CNT_W-1:0]   count
);
  import idel_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  idel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  idel_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .index  (index),
    .value  (value),
    .cmd    (cmd),
    .stat   (stat),
    .found  (found),
    .status (status),
    .count  (count)
  );

endmodule

FILE: sv/idel_ctrl.sv
module idel_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  idel_pkg::stat_t  stat,
  output idel_pkg::cmd_t   cmd
);
  import idel_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  // Result register can take a new transaction
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.ins || stat.rem || stat.srch) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (!stat.more) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: sv/idel_datapath.sv
module idel_datapath #(
  parameter int CAPACITY = idel_pkg::CAPACITY,
  localparam int ADDR_W  = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         op,
  input  logic [CNT_W-1:0]   index,
  input  logic signed [31:0] value,
  input  idel_pkg::cmd_t     cmd,
  output idel_pkg::stat_t    stat,
  output logic               found,
  output logic [1:0]         status,
  output logic [CNT_W-1:0]   count
);
  import idel_pkg::*;

  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic signed [31:0] mem [CAPACITY];

  // Entry count and latched transaction
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   ptr;
  logic signed [31:0] val;
  logic               k_ins, k_rem, k_srch;
  logic [1:0]         st;
  logic               hit;

  // Read pipeline
  logic signed [31:0] rdata;
  logic               pend;
  logic [ADDR_W-1:0]  pend_addr;

  // Decode of the incoming transaction
  logic               d_ins, d_rem, d_srch;
  logic [1:0]         d_st;
  logic [CNT_W-1:0]   d_pos;
  logic               full;

  assign full = (entry_count == CAP);

  always_comb begin
    d_ins  = 1'b0;
    d_rem  = 1'b0;
    d_srch = 1'b0;
    d_st   = ST_OK;
    d_pos  = '0;
    case (op_t'(op))
      OP_INS_HEAD: begin
        if (full) d_st = ST_FULL;
        else d_ins = 1'b1;
      end
      OP_INS_TAIL: begin
        d_pos = entry_count;
        if (full) d_st = ST_FULL;
        else d_ins = 1'b1;
      end
      OP_INS_AT: begin
        d_pos = index;
        if (index > entry_count) d_st = ST_BAD_INDEX;
        else if (full) d_st = ST_FULL;
        else d_ins = 1'b1;
      end
      OP_REM_HEAD: begin
        if (entry_count == '0) d_st = ST_EMPTY;
        else d_rem = 1'b1;
      end
      OP_REM_TAIL: begin
        d_pos = entry_count - ONE;
        if (entry_count == '0) d_st = ST_EMPTY;
        else d_rem = 1'b1;
      end
      OP_REM_AT: begin
        d_pos = index;
        if (index >= entry_count) d_st = ST_BAD_INDEX;
        else d_rem = 1'b1;
      end
      OP_SEARCH: begin
        d_srch = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sweep control: address to read next and whether one remains
  logic [CNT_W:0]    ptr_inc;
  logic              more;
  logic [CNT_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  ptr_next;

  assign ptr_inc = {1'b0, ptr} + {1'b0, ONE};

  always_comb begin
    more     = 1'b0;
    rd_ptr   = ptr;
    ptr_next = ptr;
    if (k_ins) begin
      more     = (ptr > pos);
      rd_ptr   = ptr - ONE;
      ptr_next = ptr - ONE;
    end else if (k_rem) begin
      more     = (ptr_inc < {1'b0, entry_count});
      rd_ptr   = ptr_inc[CNT_W-1:0];
      ptr_next = ptr_inc[CNT_W-1:0];
    end else if (k_srch) begin
      more     = (ptr < entry_count);
      rd_ptr   = ptr;
      ptr_next = ptr_inc[CNT_W-1:0];
    end
  end

  assign stat.ins  = d_ins;
  assign stat.rem  = d_rem;
  assign stat.srch = d_srch;
  assign stat.more = more;

  // Memory write port: moves during the sweep, new value at finish
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic signed [31:0] wdata;

  always_comb begin
    we    = 1'b0;
    waddr = pend_addr;
    wdata = rdata;
    if (cmd.step && pend && !k_srch) begin
      we = 1'b1;
    end else if (cmd.finish && k_ins) begin
      we    = 1'b1;
      waddr = pos[ADDR_W-1:0];
      wdata = val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.step && more) begin
      rdata <= mem[rd_ptr[ADDR_W-1:0]];
    end
  end

  // Transaction registers and sweep pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_ins  <= d_ins;
      k_rem  <= d_rem;
      k_srch <= d_srch;
      st     <= d_st;
      pos    <= d_pos;
      val    <= value;
      hit    <= 1'b0;
      pend   <= 1'b0;
      if (d_ins) ptr <= entry_count;
      else if (d_rem) ptr <= d_pos;
      else ptr <= '0;
    end else if (cmd.step) begin
      if (pend && k_srch && (rdata == val)) begin
        hit <= 1'b1;
      end
      pend      <= more;
      pend_addr <= ptr[ADDR_W-1:0];
      if (more) begin
        ptr <= ptr_next;
      end
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.finish) begin
      if (k_ins) entry_count <= entry_count + ONE;
      else if (k_rem) entry_count <= entry_count - ONE;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found  <= hit;
      status <= st;
      if (k_ins) count <= entry_count + ONE;
      else if (k_rem) count <= entry_count - ONE;
      else count <= entry_count;
    end
  end

endmodule
